// ----- rtl/adlif_pkg.sv -----
// Shared types, constants and register map for the adaptive LIF neuron step block.
`timescale 1ns / 1ps

package adlif_pkg;

    // register indexes on the configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY_MEMBRANE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_ADAPT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_BASE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPT_GAIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_STEPS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SURROGATE_PEAK    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_THRESHOLD = 3'd7;

    // reset values
    localparam logic [15:0] RST_DECAY_MEMBRANE    = 16'd64884;
    localparam logic [23:0] RST_CURRENT_GAIN      = 24'd26;
    localparam logic [15:0] RST_DECAY_ADAPT       = 16'd64884;
    localparam logic [30:0] RST_THRESHOLD_BASE    = 31'd983040;
    localparam logic [23:0] RST_ADAPT_GAIN        = 24'd65536;
    localparam logic [15:0] RST_REFRACTORY_STEPS  = 16'd20;
    localparam logic [23:0] RST_SURROGATE_PEAK    = 24'd1311;
    localparam logic [23:0] RST_INVERSE_THRESHOLD = 24'd4369;

    typedef struct packed {
        logic [15:0] decay_membrane;
        logic [23:0] current_gain;
        logic [15:0] decay_adapt;
        logic [30:0] threshold_base;
        logic [23:0] adapt_gain;
        logic [15:0] refractory_steps;
        logic [23:0] surrogate_peak;
        logic [23:0] inverse_threshold;
    } t_cfg;

    // datapath step codes
    typedef logic [3:0] t_op;

    localparam t_op OP_NONE     = 4'd0;
    localparam t_op OP_MUL_CUR  = 4'd1;
    localparam t_op OP_MUL_V    = 4'd2;
    localparam t_op OP_MUL_A    = 4'd3;
    localparam t_op OP_ADAPT    = 4'd4;
    localparam t_op OP_MUL_THR  = 4'd5;
    localparam t_op OP_THR      = 4'd6;
    localparam t_op OP_MAG      = 4'd7;
    localparam t_op OP_MUL_MAG  = 4'd8;
    localparam t_op OP_TRI      = 4'd9;
    localparam t_op OP_MUL_GRAD = 4'd10;

    typedef struct packed {
        logic capture;   // latch input item, apply clear
        logic commit;    // load result register, update neuron state
        t_op  op;
    } t_cmd;

endpackage

// ----- rtl/adlif_cfg.sv -----
// Configuration register file of the adaptive LIF neuron step block.
`timescale 1ns / 1ps

module adlif_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [adlif_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [adlif_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output adlif_pkg::t_cfg                  o_cfg
);
    import adlif_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay_membrane    <= RST_DECAY_MEMBRANE;
            r_cfg.current_gain      <= RST_CURRENT_GAIN;
            r_cfg.decay_adapt       <= RST_DECAY_ADAPT;
            r_cfg.threshold_base    <= RST_THRESHOLD_BASE;
            r_cfg.adapt_gain        <= RST_ADAPT_GAIN;
            r_cfg.refractory_steps  <= RST_REFRACTORY_STEPS;
            r_cfg.surrogate_peak    <= RST_SURROGATE_PEAK;
            r_cfg.inverse_threshold <= RST_INVERSE_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DECAY_MEMBRANE:    r_cfg.decay_membrane    <= i_cfg_data[15:0];
                REG_CURRENT_GAIN:      r_cfg.current_gain      <= i_cfg_data[23:0];
                REG_DECAY_ADAPT:       r_cfg.decay_adapt       <= i_cfg_data[15:0];
                REG_THRESHOLD_BASE:    r_cfg.threshold_base    <= i_cfg_data[30:0];
                REG_ADAPT_GAIN:        r_cfg.adapt_gain        <= i_cfg_data[23:0];
                REG_REFRACTORY_STEPS:  r_cfg.refractory_steps  <= i_cfg_data[15:0];
                REG_SURROGATE_PEAK:    r_cfg.surrogate_peak    <= i_cfg_data[23:0];
                REG_INVERSE_THRESHOLD: r_cfg.inverse_threshold <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/adlif_ctrl.sv -----
// Step sequencer and result handshake of the adaptive LIF neuron step block.
`timescale 1ns / 1ps

module adlif_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output adlif_pkg::t_cmd o_cmd
);
    import adlif_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MUL_CUR  = 4'd1;
    localparam logic [3:0] S_MUL_V    = 4'd2;
    localparam logic [3:0] S_MUL_A    = 4'd3;
    localparam logic [3:0] S_ADAPT    = 4'd4;
    localparam logic [3:0] S_MUL_THR  = 4'd5;
    localparam logic [3:0] S_THR      = 4'd6;
    localparam logic [3:0] S_MAG      = 4'd7;
    localparam logic [3:0] S_MUL_MAG  = 4'd8;
    localparam logic [3:0] S_TRI      = 4'd9;
    localparam logic [3:0] S_MUL_GRAD = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '{capture: 1'b0, commit: 1'b0, op: OP_NONE};
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL_CUR;
                end
            end
            S_MUL_CUR: begin
                o_cmd.op = OP_MUL_CUR;
                n_state  = S_MUL_V;
            end
            S_MUL_V: begin
                o_cmd.op = OP_MUL_V;
                n_state  = S_MUL_A;
            end
            S_MUL_A: begin
                o_cmd.op = OP_MUL_A;
                n_state  = S_ADAPT;
            end
            S_ADAPT: begin
                o_cmd.op = OP_ADAPT;
                n_state  = S_MUL_THR;
            end
            S_MUL_THR: begin
                o_cmd.op = OP_MUL_THR;
                n_state  = S_THR;
            end
            S_THR: begin
                o_cmd.op = OP_THR;
                n_state  = S_MAG;
            end
            S_MAG: begin
                o_cmd.op = OP_MAG;
                n_state  = S_MUL_MAG;
            end
            S_MUL_MAG: begin
                o_cmd.op = OP_MUL_MAG;
                n_state  = S_TRI;
            end
            S_TRI: begin
                o_cmd.op = OP_TRI;
                n_state  = S_MUL_GRAD;
            end
            S_MUL_GRAD: begin
                o_cmd.op = OP_MUL_GRAD;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/adlif_dp.sv -----
// Datapath of the adaptive LIF neuron step block: neuron state, shared multiplier, result.
`timescale 1ns / 1ps

module adlif_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adlif_pkg::t_cfg     i_cfg,
    input  adlif_pkg::t_cmd     i_cmd,
    input  logic signed [31:0]  i_spike_input,
    input  logic signed [31:0]  i_current_input,
    input  logic                i_clear_state,
    output logic                o_spike,
    output logic signed [31:0]  o_membrane,
    output logic signed [31:0]  o_adaptive_threshold,
    output logic [23:0]         o_pseudo_deriv
);
    import adlif_pkg::*;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] y;
        if (x > $signed(48'sh0000_7FFF_FFFF)) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < $signed(48'shFFFF_8000_0000)) begin
            y = $signed(32'h8000_0000);
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // neuron state
    logic signed [31:0] r_v, r_syn, r_a;
    logic [15:0]        r_refr;
    logic               r_spk;

    // item and intermediate values
    logic signed [31:0] r_z, r_cur_next;
    logic signed [47:0] r_acc;
    logic signed [31:0] r_v_new, r_a_new, r_thr;
    logic [31:0]        r_mag;
    logic [16:0]        r_tri;
    logic signed [58:0] r_prod;

    // result register
    logic               r_o_spike;
    logic signed [31:0] r_o_membrane, r_o_thr;
    logic [23:0]        r_o_grad;

    logic signed [33:0] w_mul_a;
    logic signed [24:0] w_mul_b;
    logic signed [42:0] w_pfl;
    logic signed [47:0] w_pfl_x;
    logic signed [47:0] w_sum_v, w_sum_a, w_sum_thr;
    logic signed [32:0] w_diff;
    logic [32:0]        w_abs;
    logic               w_fire;
    logic [15:0]        w_refr_next;

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.op)
            OP_MUL_CUR: begin
                w_mul_a = {{2{r_syn[31]}}, r_syn};
                w_mul_b = {1'b0, i_cfg.current_gain};
            end
            OP_MUL_V: begin
                w_mul_a = {{2{r_v[31]}}, r_v};
                w_mul_b = {9'b0, i_cfg.decay_membrane};
            end
            OP_MUL_A: begin
                w_mul_a = {{2{r_a[31]}}, r_a};
                w_mul_b = {9'b0, i_cfg.decay_adapt};
            end
            OP_MUL_THR: begin
                w_mul_a = {{2{r_a_new[31]}}, r_a_new};
                w_mul_b = {1'b0, i_cfg.adapt_gain};
            end
            OP_MUL_MAG: begin
                w_mul_a = {2'b0, r_mag};
                w_mul_b = {1'b0, i_cfg.inverse_threshold};
            end
            OP_MUL_GRAD: begin
                w_mul_a = {17'b0, r_tri};
                w_mul_b = {1'b0, i_cfg.surrogate_peak};
            end
            default: ;
        endcase
    end

    // product shifted right by 16, rounded toward minus infinity
    assign w_pfl   = r_prod[58:16];
    assign w_pfl_x = {{5{w_pfl[42]}}, w_pfl};

    assign w_sum_v   = r_acc + w_pfl_x;
    assign w_sum_a   = w_pfl_x + (r_spk ? {31'b0, ONE_Q16} : 48'sd0);
    assign w_sum_thr = {17'b0, i_cfg.threshold_base} + w_pfl_x;
    assign w_diff    = {r_v_new[31], r_v_new} - {r_thr[31], r_thr};
    assign w_abs     = w_diff[32] ? 33'(-w_diff) : w_diff;

    assign w_fire = (r_v_new >= r_thr) && (r_refr == '0);

    always_comb begin
        if (w_fire) begin
            w_refr_next = (i_cfg.refractory_steps != '0) ? i_cfg.refractory_steps - 16'd1
                                                         : '0;
        end else begin
            w_refr_next = (r_refr != '0) ? r_refr - 16'd1 : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        // product holds while the sequencer idles or waits to commit
        if (i_cmd.op != OP_NONE) begin
            r_prod <= w_mul_a * w_mul_b;
        end

        if (i_cmd.capture) begin
            r_z        <= i_spike_input;
            r_cur_next <= i_current_input;
        end

        unique case (i_cmd.op)
            OP_MUL_V: begin
                r_acc <= w_pfl_x + {{16{r_z[31]}}, r_z}
                         - (r_spk ? {17'b0, i_cfg.threshold_base} : 48'sd0);
            end
            OP_MUL_A: begin
                r_v_new <= sat32(w_sum_v);
            end
            OP_ADAPT: begin
                r_a_new <= (w_sum_a < 0) ? 32'sd0 : sat32(w_sum_a);
            end
            OP_THR: begin
                r_thr <= sat32(w_sum_thr);
            end
            OP_MAG: begin
                r_mag <= w_abs[31:0];
            end
            OP_TRI: begin
                r_tri <= (w_pfl >= $signed({26'b0, ONE_Q16})) ? 17'd0
                                                               : ONE_Q16 - w_pfl[16:0];
            end
            default: ;
        endcase

        if (i_cmd.commit) begin
            r_o_spike    <= w_fire;
            r_o_membrane <= r_v_new;
            r_o_thr      <= r_thr;
            r_o_grad     <= (r_refr != '0) ? 24'd0 : w_pfl[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_syn  <= '0;
            r_a    <= '0;
            r_refr <= '0;
            r_spk  <= 1'b0;
        end else if (i_cmd.capture && i_clear_state) begin
            r_v    <= '0;
            r_a    <= '0;
            r_refr <= '0;
            r_spk  <= 1'b0;
        end else if (i_cmd.commit) begin
            r_v    <= r_v_new;
            r_syn  <= r_cur_next;
            r_a    <= r_a_new;
            r_refr <= w_refr_next;
            r_spk  <= w_fire;
        end
    end

    assign o_spike              = r_o_spike;
    assign o_membrane           = r_o_membrane;
    assign o_adaptive_threshold = r_o_thr;
    assign o_pseudo_deriv       = r_o_grad;

endmodule

// ----- rtl/adaptive_lif_neuron_step.sv -----
// Top level of the adaptive LIF neuron step block.
//
//  port group   dir  handshake                      payload
//  in           in   i_in_valid / o_in_stall        i_spike_input, i_current_input,
//                                                   i_clear_state
//  out          out  o_out_valid / i_out_stall      o_spike, o_membrane,
//                                                   o_adaptive_threshold,
//                                                   o_pseudo_deriv
//  cfg          in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// Items are taken one at a time: eleven sequencer steps around one shared 34x25 multiplier,
// six products, the later ones on results of earlier steps, then the return to idle.
// The next item is taken while the previous result waits in the output register.
// A result that is still stalled at the end of a step holds the sequencer in its last step.
// Synchronous active-low reset restores register defaults and zeroes the neuron state.
`timescale 1ns / 1ps

module adaptive_lif_neuron_step (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [31:0]               i_spike_input,
    input  logic signed [31:0]               i_current_input,
    input  logic                             i_clear_state,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_spike,
    output logic signed [31:0]               o_membrane,
    output logic signed [31:0]               o_adaptive_threshold,
    output logic [23:0]                      o_pseudo_deriv,
    input  logic                             i_cfg_we,
    input  logic [adlif_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [adlif_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import adlif_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;

    adlif_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    adlif_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    adlif_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (w_cfg),
        .i_cmd                (w_cmd),
        .i_spike_input        (i_spike_input),
        .i_current_input      (i_current_input),
        .i_clear_state        (i_clear_state),
        .o_spike              (o_spike),
        .o_membrane           (o_membrane),
        .o_adaptive_threshold (o_adaptive_threshold),
        .o_pseudo_deriv       (o_pseudo_deriv)
    );

endmodule
